// ===== rtl/tcet_pkg.sv =====
// ----------------------------------------------------------------------------
// Tracker cell transcoder package
// Transaction types, event kind codes, sequencer states and the tempo table
// used by the transcoder; its checker uses the event type and kind codes.
// ----------------------------------------------------------------------------
package tcet_pkg;

  typedef struct packed {
    logic [8:0] row_tick;
    logic [8:0] break_row;
    logic       first_channel;
    logic       track_start;
    logic [7:0] note_number;
    logic [7:0] instrument_number;
    logic [7:0] volume_level;
    logic [7:0] effect_byte;
  } cell_in_t;

  typedef struct packed {
    logic [7:0] event_tick;
    logic [3:0] event_kind;
    logic [7:0] note_code;
    logic [7:0] event_value;
    logic       last_event;
  } event_out_t;

  typedef enum logic [3:0] {
    KIND_NOTE      = 4'd0,
    KIND_INSTR     = 4'd1,
    KIND_BEND_TGT  = 4'd2,
    KIND_VOLUME    = 4'd3,
    KIND_BEND      = 4'd4,
    KIND_RETRIG    = 4'd5,
    KIND_PAN       = 4'd6,
    KIND_EXT_TEMPO = 4'd7,
    KIND_SPEED     = 4'd8,
    KIND_BREAK     = 4'd9
  } event_kind_t;

  typedef enum logic [3:0] {
    CMD_BEND_DOWN = 4'h1,
    CMD_BEND_UP   = 4'h2,
    CMD_PORTA     = 4'h3,
    CMD_RETRIG    = 4'h4,
    CMD_PAN       = 4'hB,
    CMD_TEMPO     = 4'hF
  } effect_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } seq_state_t;

  // Event slots in emission order.
  localparam int unsigned SLOT_BREAK  = 0;
  localparam int unsigned SLOT_INSTR  = 1;
  localparam int unsigned SLOT_TARGET = 2;
  localparam int unsigned SLOT_NOTE   = 3;
  localparam int unsigned SLOT_EFFECT = 4;
  localparam int unsigned SLOT_SPEED  = 5;
  localparam int unsigned NUM_SLOTS   = 6;

  localparam logic [7:0] INSTR_NONE  = 8'hF0;
  localparam logic [7:0] NOTE_OFFSET = 8'd47;
  localparam logic [7:0] VOL_NONE    = 8'hFF;
  localparam logic [8:0] TICK_NOBRK  = 9'd255;
  localparam logic [5:0] SPEED_MUL   = 6'd50;

  // Extended tempo for each effect data nibble.
  function automatic logic [7:0] tempo_lookup(input logic [3:0] data);
    logic [7:0] t;
    unique case (data)
      4'd0:    t = 8'd125;
      4'd1:    t = 8'd90;
      4'd2:    t = 8'd122;
      4'd3:    t = 8'd108;
      4'd4:    t = 8'd121;
      4'd5:    t = 8'd113;
      4'd6:    t = 8'd121;
      4'd7:    t = 8'd114;
      4'd8:    t = 8'd120;
      default: t = 8'd125;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/tracker_cell_to_event_transcoder.sv =====
// ----------------------------------------------------------------------------
// Tracker cell to event transcoder
// Turns one four-byte pattern cell into an ordered run of track events and
// tracks the current instrument of the track.
// ----------------------------------------------------------------------------
//  Channel  Ports                          Direction  Payload
//  cell     in_valid / in_ready / in_data  input      tcet_pkg::cell_in_t
//  event    out_valid / out_ready/out_data output     tcet_pkg::event_out_t
//
//  A cell is taken only in the idle state and its event slots are latched as a mask.
//  A single event builder then emits one event per cycle while the output
//  register is free, lowest slot first; no new cell is taken until the last
//  event is emitted, and a cell with no events returns straight to idle.
//  A stalled output register holds the sequencer in place.
//  rst_n clears the sequencer and the output valid and sets the current instrument to INSTR_NONE.
// ----------------------------------------------------------------------------
module tracker_cell_to_event_transcoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tcet_pkg::cell_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tcet_pkg::event_out_t out_data
);

  localparam int unsigned NS = tcet_pkg::NUM_SLOTS;

  tcet_pkg::seq_state_t state_r, state_nxt;
  logic [NS-1:0]        mask_r, mask_nxt;
  logic [7:0]           cur_instr_r, cur_instr_nxt;
  tcet_pkg::cell_in_t   cell_r;
  logic                 out_valid_r, out_valid_nxt;
  tcet_pkg::event_out_t out_data_r, out_data_nxt;

  logic                 in_fire;
  logic                 out_free;
  logic                 emit;
  logic [7:0]           eff_instr;
  logic                 has_note;
  logic                 has_vol;
  logic [3:0]           cmd_in;
  logic [NS-1:0]        slots_in;
  logic [NS-1:0]        pick;
  logic [3:0]           cmd;
  logic [3:0]           data;
  logic [7:0]           vol4;
  logic [9:0]           speed_prod;
  tcet_pkg::event_out_t ev;

  assign in_ready = (state_r == tcet_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign emit     = (state_r == tcet_pkg::ST_EMIT) && (mask_r != '0) && out_free;

  // Slot decode of the incoming cell.
  always_comb begin
    eff_instr = in_data.track_start ? tcet_pkg::INSTR_NONE : cur_instr_r;
    has_note  = (in_data.note_number != 8'd0);
    has_vol   = (in_data.volume_level != 8'd0) &&
                (in_data.volume_level != tcet_pkg::VOL_NONE);
    cmd_in    = in_data.effect_byte[7:4];
    slots_in  = '0;
    slots_in[tcet_pkg::SLOT_BREAK]  = (in_data.row_tick == in_data.break_row) &&
                                      in_data.first_channel &&
                                      (in_data.row_tick != tcet_pkg::TICK_NOBRK);
    slots_in[tcet_pkg::SLOT_INSTR]  = has_note &&
                                      (in_data.instrument_number != eff_instr);
    slots_in[tcet_pkg::SLOT_TARGET] = (cmd_in == tcet_pkg::CMD_PORTA);
    slots_in[tcet_pkg::SLOT_NOTE]   = has_note || has_vol;
    slots_in[tcet_pkg::SLOT_EFFECT] = (cmd_in == tcet_pkg::CMD_BEND_DOWN) ||
                                      (cmd_in == tcet_pkg::CMD_BEND_UP) ||
                                      (cmd_in == tcet_pkg::CMD_RETRIG) ||
                                      (cmd_in == tcet_pkg::CMD_PAN) ||
                                      (cmd_in == tcet_pkg::CMD_TEMPO);
    slots_in[tcet_pkg::SLOT_SPEED]  = (cmd_in == tcet_pkg::CMD_TEMPO);
  end

  // Shared event builder: one slot per cycle, while the output is free, from the latched cell.
  always_comb begin
    pick       = mask_r & (~mask_r + {{(NS-1){1'b0}}, 1'b1});
    cmd        = cell_r.effect_byte[7:4];
    data       = cell_r.effect_byte[3:0];
    vol4       = {cell_r.volume_level[5:0], 2'b00};
    speed_prod = {6'd0, data} * {4'd0, tcet_pkg::SPEED_MUL};
    ev             = '0;
    ev.event_tick  = cell_r.row_tick[7:0];
    ev.last_event  = ((mask_r & ~pick) == '0);
    priority if (pick[tcet_pkg::SLOT_BREAK]) begin
      ev.event_kind = tcet_pkg::KIND_BREAK;
    end else if (pick[tcet_pkg::SLOT_INSTR]) begin
      ev.event_kind  = tcet_pkg::KIND_INSTR;
      ev.event_value = cell_r.instrument_number;
    end else if (pick[tcet_pkg::SLOT_TARGET]) begin
      ev.event_kind  = tcet_pkg::KIND_BEND_TGT;
      ev.event_value = {4'd0, data};
    end else if (pick[tcet_pkg::SLOT_NOTE]) begin
      if (cell_r.note_number != 8'd0) begin
        ev.event_kind  = tcet_pkg::KIND_NOTE;
        ev.note_code   = cell_r.note_number + tcet_pkg::NOTE_OFFSET;
        ev.event_value = ((cell_r.volume_level != 8'd0) &&
                          (cell_r.volume_level != tcet_pkg::VOL_NONE)) ?
                         vol4 : tcet_pkg::VOL_NONE;
      end else begin
        ev.event_kind  = tcet_pkg::KIND_VOLUME;
        ev.event_value = vol4;
      end
    end else if (pick[tcet_pkg::SLOT_EFFECT]) begin
      unique case (cmd)
        tcet_pkg::CMD_BEND_DOWN: begin
          ev.event_kind  = tcet_pkg::KIND_BEND;
          ev.event_value = 8'd0 - {4'd0, data};
        end
        tcet_pkg::CMD_BEND_UP: begin
          ev.event_kind  = tcet_pkg::KIND_BEND;
          ev.event_value = {4'd0, data};
        end
        tcet_pkg::CMD_RETRIG: begin
          ev.event_kind  = tcet_pkg::KIND_RETRIG;
          ev.event_value = {4'd0, data};
        end
        tcet_pkg::CMD_PAN: begin
          ev.event_kind = tcet_pkg::KIND_PAN;
          // Nine steps per nibble either side of the two center codes.
          if (data < 4'd7) begin
            ev.event_value = 8'd0 - ({4'd0, 4'd7 - data} * 8'd9);
          end else if (data > 4'd8) begin
            ev.event_value = {4'd0, data - 4'd8} * 8'd9;
          end else begin
            ev.event_value = 8'd0;
          end
        end
        default: begin
          ev.event_kind  = tcet_pkg::KIND_EXT_TEMPO;
          ev.event_value = tcet_pkg::tempo_lookup(data);
        end
      endcase
    end else begin
      ev.event_kind  = tcet_pkg::KIND_SPEED;
      ev.event_value = {3'd0, speed_prod[9:5]};
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcet_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = tcet_pkg::ST_EMIT;
        end
      end
      tcet_pkg::ST_EMIT: begin
        if ((mask_r == '0) || (emit && ((mask_r & ~pick) == '0))) begin
          state_nxt = tcet_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tcet_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output updates.
  always_comb begin
    mask_nxt      = mask_r;
    cur_instr_nxt = cur_instr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      tcet_pkg::ST_IDLE: begin
        if (in_fire) begin
          mask_nxt      = slots_in;
          cur_instr_nxt = has_note ? in_data.instrument_number : eff_instr;
        end
      end
      tcet_pkg::ST_EMIT: begin
        if (emit) begin
          mask_nxt      = mask_r & ~pick;
          out_valid_nxt = 1'b1;
          out_data_nxt  = ev;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcet_pkg::ST_IDLE;
      mask_r      <= '0;
      cur_instr_r <= tcet_pkg::INSTR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      cur_instr_r <= cur_instr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cell_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/tcet_checker.sv =====
// ----------------------------------------------------------------------------
// Tracker cell transcoder checker
// Port-level assertions on the transcoder, attached by a bind statement.
// ----------------------------------------------------------------------------
module tcet_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input tcet_pkg::event_out_t out_data
);

  // A stalled event transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("event changed while stalled");

  // The block works on one cell at a time.
  a_busy_after_cell: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("cell taken while the previous one is in flight");

  // New events are only produced while a cell is being worked on.
  a_event_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("event produced with no cell in flight");

  // Event kinds stay within the defined codes.
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.event_kind <= tcet_pkg::KIND_BREAK)
    else $error("undefined event kind");

  // A note code appears only on note events.
  a_note_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_kind != tcet_pkg::KIND_NOTE) |->
      out_data.note_code == 8'd0)
    else $error("note code on a non-note event");

endmodule

bind tracker_cell_to_event_transcoder tcet_checker u_tcet_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
